[sv/hslc_pkg.sv]
// shared types, pattern tables and codes for the http start-line classifier
package hslc_pkg;

	// parameter defaults
	localparam int PATH_MAX_DEF     = 64;
	localparam int PREFIX_BYTES_DEF = 128;

	// stream widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 48;

	// result queue depth, holds two results of one byte plus slack
	localparam int RQ_DEPTH = 4;

	// candidate patterns: seven methods in priority order, then the response tag
	localparam int NPAT     = 8;
	localparam int HTTP_PAT = 7;
	localparam int PAT_SPAN = 8;

	// offset of '0' in all three status digits: '0'*100 + '0'*10 + '0'
	localparam logic [15:0] STATUS_BIAS = 16'd5328;

	localparam logic [7:0] PAT_TEXT [NPAT][PAT_SPAN] = '{
		'{"G", "E", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "O", "S", "T", " ", 8'h00, 8'h00, 8'h00},
		'{"P", "U", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "A", "T", "C", "H", " ", 8'h00, 8'h00},
		'{"D", "E", "L", "E", "T", "E", " ", 8'h00},
		'{"H", "E", "A", "D", " ", 8'h00, 8'h00, 8'h00},
		'{"O", "P", "T", "I", "O", "N", "S", " "},
		'{"H", "T", "T", "P", "/", "1", ".", 8'h00}
	};

	localparam logic [3:0] PAT_LEN [NPAT] = '{
		4'd4, 4'd5, 4'd4, 4'd6, 4'd7, 4'd5, 4'd8, 4'd7
	};

	// byte codes that end a path
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	// result kind codes
	localparam logic RK_PATH    = 1'b0;
	localparam logic RK_SUMMARY = 1'b1;

	// message kind codes
	localparam logic [1:0] MK_UNKNOWN  = 2'd0;
	localparam logic [1:0] MK_REQUEST  = 2'd1;
	localparam logic [1:0] MK_RESPONSE = 2'd2;

	// method code for no method
	localparam logic [2:0] METHOD_NONE = 3'd0;

	typedef struct packed {
		logic               result_kind;
		logic [7:0]         path_char;
		logic [5:0]         path_index;
		logic [1:0]         message_kind;
		logic [2:0]         method_code;
		logic signed [15:0] resp_status;
		logic [5:0]         path_length;
		logic               end_of_run;
	} result_t;

endpackage

[sv/http_start_line_classifier.sv]
// http start-line classifier: method / response detection, path extraction, status
//
// Takes the leading payload bytes of one message, one byte per item, and
// classifies it as one of seven request methods, as a response ("HTTP/1."),
// or as unknown. For a request each path byte after the method's space is
// returned as a path item; the path ends at space, CR, LF, NUL or after
// PATH_MAX-1 bytes. The byte marked tlast closes the message with a summary
// item (tlast high) carrying the kind, method, status and path length; all
// state then returns to reset. One byte is taken per clock unless stalled:
// it sits in an input register while the classifier updates its state, and
// its results enter a four-entry result queue. A byte yields zero, one or
// two results; the queue drains one result per cycle while m_tready is high,
// so the sustained rate is one byte per cycle as long as the results do not
// exceed one per cycle on average, and the input stalls while fewer than two
// queue entries are free.
module http_start_line_classifier #(
	parameter int PATH_MAX     = hslc_pkg::PATH_MAX_DEF,
	parameter int PREFIX_BYTES = hslc_pkg::PREFIX_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hslc_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] data_byte
	input  logic                              s_tlast,   // last_byte
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [7:0] path_char, [13:8] path_index, [15:14] message_kind, [18:16] method_code,
	// [34:19] resp_status, [40:35] path_length, [47:41] zero
	output logic [hslc_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tuser,   // result_kind
	output logic                              m_tlast    // end_of_run
);
	import hslc_pkg::*;

	localparam int BPW = $clog2(PREFIX_BYTES + 1);
	localparam int PCW = $clog2(PATH_MAX);
	localparam int EXW = PCW + 6;
	localparam int RQW = $clog2(RQ_DEPTH);
	localparam int RCW = $clog2(RQ_DEPTH + 1);

	localparam logic [BPW-1:0] PREFIX_POS = BPW'(PREFIX_BYTES);
	localparam logic [PCW-1:0] PATH_LIMIT = PCW'(PATH_MAX - 1);

	// first alive pattern already fully seen, NPAT when none
	function automatic logic [3:0] find_match(input logic [NPAT-1:0] alive,
	                                          input logic [BPW-1:0] pos);
		logic [3:0] hit;
		hit = 4'(NPAT);
		for (int k = NPAT - 1; k >= 0; k--) begin
			if (alive[k] && pos >= BPW'(PAT_LEN[k]))
				hit = 4'(k);
		end
		return hit;
	endfunction

	// classifier state
	logic [BPW-1:0]    byte_position_q;
	logic [NPAT-1:0]   pattern_alive_q;
	logic              path_active_q;
	logic              path_finished_q;
	logic [PCW-1:0]    path_count_q;
	logic [15:0]       status_acc_q;

	// input register
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;

	// result queue
	result_t           rq_mem [RQ_DEPTH];
	logic [RQW-1:0]    rq_wr_q;
	logic [RQW-1:0]    rq_rd_q;
	logic [RCW-1:0]    rq_count_q;

	logic              adv;
	logic              pop;
	logic [1:0]        push_n;

	// next-state and result logic
	logic [7:0]        b_eff;
	logic              stop_char;
	logic              emit;
	logic              path_active_n;
	logic              path_finished_n;
	logic [PCW-1:0]    path_count_n;
	logic [NPAT-1:0]   pattern_alive_n;
	logic [BPW-1:0]    byte_position_n;
	logic [15:0]       status_acc_n;
	logic [3:0]        match_old;
	logic [3:0]        match_new;
	logic [EXW-1:0]    idx_ext;
	logic [EXW-1:0]    len_ext;
	result_t           path_res;
	result_t           sum_res;
	result_t           first_res;

	// handshakes
	assign adv      = valid_s1 && (rq_count_q <= RCW'(RQ_DEPTH - 2));
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = (rq_count_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign push_n   = adv ? (2'(emit) + 2'(last_s1)) : 2'd0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

	// per-byte classification
	always_comb begin
		b_eff     = (byte_position_q < PREFIX_POS) ? byte_s1 : 8'h00;
		stop_char = (b_eff == CHAR_SPACE) || (b_eff == CHAR_CR) ||
		            (b_eff == CHAR_LF) || (b_eff == CHAR_NUL);
		match_old = find_match(pattern_alive_q, byte_position_q);

		path_active_n   = path_active_q;
		path_finished_n = path_finished_q;
		path_count_n    = path_count_q;
		emit            = 1'b0;

		// path run
		if (path_active_q && !path_finished_q) begin
			if (stop_char || path_count_q >= PATH_LIMIT) begin
				path_finished_n = 1'b1;
				path_active_n   = 1'b0;
			end else begin
				emit         = 1'b1;
				path_count_n = path_count_q + PCW'(1);
				if (path_count_n >= PATH_LIMIT) begin
					path_finished_n = 1'b1;
					path_active_n   = 1'b0;
				end
			end
		end

		// pattern elimination over the first eight bytes
		pattern_alive_n = pattern_alive_q;
		if (byte_position_q < BPW'(PAT_SPAN)) begin
			for (int k = 0; k < NPAT; k++) begin
				if (byte_position_q < BPW'(PAT_LEN[k]) &&
				    b_eff != PAT_TEXT[k][byte_position_q[2:0]])
					pattern_alive_n[k] = 1'b0;
			end
			for (int k = 0; k < HTTP_PAT; k++) begin
				if (pattern_alive_n[k] &&
				    byte_position_q + BPW'(1) == BPW'(PAT_LEN[k]) &&
				    !path_finished_n)
					path_active_n = 1'b1;
			end
		end

		// status digits at positions nine to eleven
		status_acc_n = status_acc_q;
		if (byte_position_q == BPW'(9))
			status_acc_n = status_acc_q + 16'(b_eff) * 16'd100;
		else if (byte_position_q == BPW'(10))
			status_acc_n = status_acc_q + 16'(b_eff) * 16'd10;
		else if (byte_position_q == BPW'(11))
			status_acc_n = status_acc_q + 16'(b_eff);

		byte_position_n = (byte_position_q < PREFIX_POS) ?
		                  byte_position_q + BPW'(1) : byte_position_q;
		match_new = find_match(pattern_alive_n, byte_position_n);

		// path result
		idx_ext               = EXW'(path_count_q);
		path_res              = '0;
		path_res.result_kind  = RK_PATH;
		path_res.path_char    = b_eff;
		path_res.path_index   = idx_ext[5:0];
		path_res.message_kind = MK_REQUEST;
		path_res.method_code  = (match_old < 4'(HTTP_PAT)) ?
		                        3'(match_old + 4'd1) : METHOD_NONE;

		// summary result
		len_ext              = EXW'(path_count_n);
		sum_res              = '0;
		sum_res.result_kind  = RK_SUMMARY;
		sum_res.path_length  = len_ext[5:0];
		sum_res.end_of_run   = 1'b1;
		if (match_new < 4'(HTTP_PAT)) begin
			sum_res.message_kind = MK_REQUEST;
			sum_res.method_code  = 3'(match_new + 4'd1);
		end else if (match_new == 4'(HTTP_PAT)) begin
			sum_res.message_kind = MK_RESPONSE;
			sum_res.resp_status  = status_acc_n - STATUS_BIAS;
		end else begin
			sum_res.message_kind = MK_UNKNOWN;
		end

		first_res = emit ? path_res : sum_res;
	end

	// state update, back to reset after a summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			pattern_alive_q <= '1;
			path_active_q   <= 1'b0;
			path_finished_q <= 1'b0;
			path_count_q    <= '0;
			status_acc_q    <= '0;
		end else if (adv) begin
			if (last_s1) begin
				byte_position_q <= '0;
				pattern_alive_q <= '1;
				path_active_q   <= 1'b0;
				path_finished_q <= 1'b0;
				path_count_q    <= '0;
				status_acc_q    <= '0;
			end else begin
				byte_position_q <= byte_position_n;
				pattern_alive_q <= pattern_alive_n;
				path_active_q   <= path_active_n;
				path_finished_q <= path_finished_n;
				path_count_q    <= path_count_n;
				status_acc_q    <= status_acc_n;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			rq_mem[rq_wr_q] <= first_res;
		if (push_n == 2'd2)
			rq_mem[rq_wr_q + RQW'(1)] <= sum_res;
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q    <= '0;
			rq_rd_q    <= '0;
			rq_count_q <= '0;
		end else begin
			rq_wr_q    <= rq_wr_q + RQW'(push_n);
			rq_rd_q    <= rq_rd_q + RQW'(pop);
			rq_count_q <= rq_count_q + RCW'(push_n) - RCW'(pop);
		end
	end

	// result port
	always_comb begin
		m_tdata = {7'b0,
		           rq_mem[rq_rd_q].path_length,
		           rq_mem[rq_rd_q].resp_status,
		           rq_mem[rq_rd_q].method_code,
		           rq_mem[rq_rd_q].message_kind,
		           rq_mem[rq_rd_q].path_index,
		           rq_mem[rq_rd_q].path_char};
		m_tuser = rq_mem[rq_rd_q].result_kind;
		m_tlast = rq_mem[rq_rd_q].end_of_run;
	end

`ifndef SYNTHESIS
	// queue never overfills
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_count_q <= RCW'(RQ_DEPTH))
		else $error("result queue overflow");

	// a closing byte returns the classifier to its start state
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> byte_position_q == '0 && pattern_alive_q == '1)
		else $error("state not cleared after summary");

	// a path is never running and finished at once
	a_path_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(path_active_q && path_finished_q))
		else $error("path active and finished together");

	// path count stays within the limit
	a_path_limit: assert property (@(posedge clk) disable iff (!arst_n)
		path_count_q <= PATH_LIMIT)
		else $error("path count beyond limit");
`endif

endmodule
